// ----- sv/srs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo envelope ratio shaper package
// Shared widths, register indexes, reset values, sequencer states and the
// control and status bundles of the divider.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int COEF_WIDTH         = 24;
   localparam int FACTOR_WIDTH       = 24;
   localparam int GAIN_FRAC_BITS     = 20;

   localparam int DEF_SAMPLE_WIDTH   = 24;
   localparam int DEF_ENV_WIDTH      = 32;
   localparam int DEF_FACTOR_FRAC    = 16;

   localparam int CSR_INDEX_WIDTH    = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAST_ALPHA = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOW_ALPHA = 2'd2;

   localparam logic [COEF_WIDTH-1:0] GAIN_RESET       = 24'd1048576;
   localparam logic [COEF_WIDTH-1:0] FAST_ALPHA_RESET = 24'd8388608;
   localparam logic [COEF_WIDTH-1:0] SLOW_ALPHA_RESET = 24'd1048576;

   typedef enum logic [11:0] {
      ST_IDLE = 12'b0000_0000_0001,
      ST_GAIN = 12'b0000_0000_0010,
      ST_GSAT = 12'b0000_0000_0100,
      ST_DIF  = 12'b0000_0000_1000,
      ST_HI   = 12'b0000_0001_0000,
      ST_LO   = 12'b0000_0010_0000,
      ST_UPD  = 12'b0000_0100_0000,
      ST_DCHK = 12'b0000_1000_0000,
      ST_DIV  = 12'b0001_0000_0000,
      ST_OMUL = 12'b0010_0000_0000,
      ST_OSAT = 12'b0100_0000_0000,
      ST_DONE = 12'b1000_0000_0000
   } srs_state_type;

   typedef struct packed {
      logic start;
   } srs_div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } srs_div_sts_type;

endpackage
`default_nettype wire

// ----- sv/srs_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned multiplier with a registered product, shared by the gain, the
// envelope followers and the output scaling.
// ----------------------------------------------------------------------------
module srs_mul #(
   parameter int A_WIDTH = srs_pkg::COEF_WIDTH,
   parameter int B_WIDTH = srs_pkg::COEF_WIDTH
) (
   input  logic                       clock,
   input  logic [A_WIDTH-1:0]         mul_a,
   input  logic [B_WIDTH-1:0]         mul_b,
   output logic [A_WIDTH+B_WIDTH-1:0] mul_p
);

   logic [A_WIDTH+B_WIDTH-1:0] prod_ff;
   logic [A_WIDTH+B_WIDTH-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule
`default_nettype wire

// ----- sv/srs_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Envelope ratio divider
// Restoring divider that forms fast * 2^FACTOR_FRAC_BITS / slow one quotient
// bit per cycle, saturating to all ones when the quotient would overflow.
// ----------------------------------------------------------------------------
module srs_div #(
   parameter int ENV_WIDTH        = srs_pkg::DEF_ENV_WIDTH,
   parameter int FACTOR_FRAC_BITS = srs_pkg::DEF_FACTOR_FRAC
) (
   input  logic                                clock,
   input  logic                                reset,
   input  srs_pkg::srs_div_ctl_type            div_ctl,
   input  logic [ENV_WIDTH-1:0]                div_dividend,
   input  logic [ENV_WIDTH-1:0]                div_divisor,
   output srs_pkg::srs_div_sts_type            div_sts,
   output logic [srs_pkg::FACTOR_WIDTH-1:0]    div_quotient
);

   import srs_pkg::*;

   localparam int SH   = FACTOR_WIDTH - FACTOR_FRAC_BITS;
   localparam int CNTW = $clog2(FACTOR_WIDTH + 1);

   logic [ENV_WIDTH-1:0]    rem_ff, rem_in;
   logic [ENV_WIDTH-1:0]    dvs_ff, dvs_in;
   logic [FACTOR_WIDTH-1:0] feed_ff, feed_in;
   logic [FACTOR_WIDTH-1:0] quo_ff, quo_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [ENV_WIDTH+SH-1:0] limit;
   logic                    over;
   logic [ENV_WIDTH:0]      rem_sh;
   logic [ENV_WIDTH:0]      rem_diff;
   logic                    ge;

   assign limit    = {div_divisor, {SH{1'b0}}};
   assign over     = (ENV_WIDTH + SH)'(div_dividend) >= limit;
   assign rem_sh   = {rem_ff, feed_ff[FACTOR_WIDTH-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign ge       = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      feed_in = feed_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctl.start) begin
         dvs_in = div_divisor;
         if (over) begin
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = ENV_WIDTH'(div_dividend >> SH);
            feed_in = {div_dividend[SH-1:0], {FACTOR_FRAC_BITS{1'b0}}};
            quo_in  = '0;
            cnt_in  = CNTW'(FACTOR_WIDTH);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? rem_diff[ENV_WIDTH-1:0] : rem_sh[ENV_WIDTH-1:0];
         feed_in = feed_ff << 1;
         quo_in  = {quo_ff[FACTOR_WIDTH-2:0], ge};
         cnt_in  = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      feed_ff <= feed_in;
      quo_ff  <= quo_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign div_quotient = quo_ff;

endmodule
`default_nettype wire

// ----- sv/stereo_envelope_ratio_shaper_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo envelope ratio shaper
// Gains each channel, runs a fast and a slow envelope follower per channel and
// scales the gained sample by the held fast/slow envelope ratio.
// ----------------------------------------------------------------------------
// The divider runs its bit-serial loop only for a channel whose slow envelope
// is nonzero and whose ratio does not saturate. It produces one quotient bit
// per cycle, while the single shared multiplier serializes the gain, follower
// and output products. A new pair is taken once the previous result sits in
// the output register.
module stereo_envelope_ratio_shaper_core #(
   parameter int SAMPLE_WIDTH     = srs_pkg::DEF_SAMPLE_WIDTH,
   parameter int ENV_WIDTH        = srs_pkg::DEF_ENV_WIDTH,
   parameter int FACTOR_FRAC_BITS = srs_pkg::DEF_FACTOR_FRAC
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [srs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [srs_pkg::COEF_WIDTH-1:0]       csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_left,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_right,
   input  logic                                 req_block_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_out_left,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_out_right
);

   import srs_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int EW     = ENV_WIDTH;
   localparam int CW     = COEF_WIDTH;
   localparam int MUL_AW = (SW > CW) ? SW : CW;
   localparam int PW     = MUL_AW + CW;
   localparam logic [PW-1:0] HALF_P = PW'(1) << (SW - 1);
   localparam logic [PW-1:0] MAXP_P = HALF_P - PW'(1);

   srs_state_type          state_ff, state_in;
   logic [CW-1:0]          gain_ff, gain_in;
   logic [CW-1:0]          fast_alpha_ff, fast_alpha_in;
   logic [CW-1:0]          slow_alpha_ff, slow_alpha_in;
   logic [SW-1:0]          samp_ff [2];
   logic [SW-1:0]          samp_in [2];
   logic                   ch_ff, ch_in;
   logic                   slow_ff, slow_in;
   logic                   bank_ff, bank_in;
   logic [SW-1:0]          gmag_ff, gmag_in;
   logic                   neg_ff, neg_in;
   logic [EW-1:0]          m_ff, m_in;
   logic [EW-1:0]          d_ff, d_in;
   logic                   up_ff, up_in;
   logic [2*CW-1:0]        acc_ff, acc_in;
   logic [EW-1:0]          fe_ff, fe_in;
   logic [EW-1:0]          se_ff, se_in;
   logic [FACTOR_WIDTH-1:0] held_ff, held_in;
   logic [SW-1:0]          res_ff [2];
   logic [SW-1:0]          res_in [2];
   logic [SW-1:0]          rsp_left_ff, rsp_left_in;
   logic [SW-1:0]          rsp_right_ff, rsp_right_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]          env_ff [2][2][2];
   logic [EW-1:0]          env_in [2][2][2];

   logic                   req_accept;
   logic                   rsp_load;
   logic [MUL_AW-1:0]      mul_a;
   logic [CW-1:0]          mul_b;
   logic [PW-1:0]          mul_p;
   srs_div_ctl_type        div_ctl;
   srs_div_sts_type        div_sts;
   logic [FACTOR_WIDTH-1:0] div_quotient;

   logic [SW-1:0]          samp_sel;
   logic [SW-1:0]          xmag;
   logic [CW-1:0]          alpha_sel;
   logic [EW-1:0]          env_cur;
   logic [EW+CW-1:0]       dx;
   logic [2*CW:0]          step_sum;
   logic [EW-1:0]          step;
   logic [EW-1:0]          env_new;
   logic [SW-1:0]          gmag_new;
   logic [SW+EW-1:0]       gm_wide;
   logic [SW-1:0]          omag;
   logic [SW-1:0]          res_new;

   function automatic logic [SW-1:0] sat_mag(input logic neg, input logic [PW-1:0] v);
      logic [SW-1:0] r;
      if (neg) begin
         r = (v > HALF_P) ? HALF_P[SW-1:0] : v[SW-1:0];
      end else begin
         r = (v > MAXP_P) ? MAXP_P[SW-1:0] : v[SW-1:0];
      end
      return r;
   endfunction

   srs_mul #(
      .A_WIDTH (MUL_AW),
      .B_WIDTH (CW)
   ) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   srs_div #(
      .ENV_WIDTH        (EW),
      .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .div_ctl      (div_ctl),
      .div_dividend (fe_ff),
      .div_divisor  (se_ff),
      .div_sts      (div_sts),
      .div_quotient (div_quotient)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign samp_sel  = samp_ff[ch_ff];
   assign xmag      = samp_sel[SW-1] ? (~samp_sel + SW'(1)) : samp_sel;
   assign alpha_sel = slow_ff ? slow_alpha_ff : fast_alpha_ff;
   assign env_cur   = env_ff[ch_ff][slow_ff][bank_ff];
   assign dx        = {{CW{1'b0}}, d_ff};
   assign step_sum  = {1'b0, acc_ff} + (2*CW+1)'(mul_p[2*CW-1:CW]);
   assign step      = step_sum[EW-1:0];
   assign env_new   = up_ff ? (env_cur + step) : (env_cur - step);
   assign gmag_new  = sat_mag(samp_sel[SW-1], mul_p >> GAIN_FRAC_BITS);
   assign gm_wide   = {gmag_new, {EW{1'b0}}};
   assign omag      = sat_mag(neg_ff, mul_p >> FACTOR_FRAC_BITS);
   assign res_new   = neg_ff ? (~omag + SW'(1)) : omag;

   always_comb begin
      state_in      = state_ff;
      samp_in       = samp_ff;
      ch_in         = ch_ff;
      slow_in       = slow_ff;
      bank_in       = bank_ff;
      gmag_in       = gmag_ff;
      neg_in        = neg_ff;
      m_in          = m_ff;
      d_in          = d_ff;
      up_in         = up_ff;
      acc_in        = acc_ff;
      fe_in         = fe_ff;
      se_in         = se_ff;
      held_in       = held_ff;
      res_in        = res_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      env_in        = env_ff;
      mul_a         = '0;
      mul_b         = '0;
      div_ctl.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               samp_in[0] = req_sample_left;
               samp_in[1] = req_sample_right;
               ch_in      = 1'b0;
               slow_in    = 1'b0;
               if (req_block_start) begin
                  held_in = '0;
               end
               state_in = ST_GAIN;
            end
         end
         ST_GAIN: begin
            mul_a    = MUL_AW'(xmag);
            mul_b    = gain_ff;
            state_in = ST_GSAT;
         end
         ST_GSAT: begin
            gmag_in  = gmag_new;
            neg_in   = samp_sel[SW-1];
            m_in     = gm_wide[SW+EW-1:SW];
            state_in = ST_DIF;
         end
         ST_DIF: begin
            up_in    = (m_ff >= env_cur);
            d_in     = (m_ff >= env_cur) ? (m_ff - env_cur) : (env_cur - m_ff);
            state_in = ST_HI;
         end
         ST_HI: begin
            mul_a    = MUL_AW'(dx[2*CW-1:CW]);
            mul_b    = alpha_sel;
            state_in = ST_LO;
         end
         ST_LO: begin
            acc_in   = mul_p[2*CW-1:0];
            mul_a    = MUL_AW'(dx[CW-1:0]);
            mul_b    = alpha_sel;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            env_in[ch_ff][slow_ff][bank_ff] = env_new;
            if (!slow_ff) begin
               fe_in    = env_new;
               slow_in  = 1'b1;
               state_in = ST_DIF;
            end else begin
               se_in    = env_new;
               state_in = ST_DCHK;
            end
         end
         ST_DCHK: begin
            if (se_ff != '0) begin
               div_ctl.start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_OMUL;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               held_in  = div_quotient;
               state_in = ST_OMUL;
            end
         end
         ST_OMUL: begin
            mul_a    = MUL_AW'(gmag_ff);
            mul_b    = held_ff;
            state_in = ST_OSAT;
         end
         ST_OSAT: begin
            res_in[ch_ff] = res_new;
            if (!ch_ff) begin
               ch_in    = 1'b1;
               slow_in  = 1'b0;
               state_in = ST_GAIN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_left_in  = res_ff[0];
               rsp_right_in = res_ff[1];
               bank_in      = ~bank_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      gain_in       = gain_ff;
      fast_alpha_in = fast_alpha_ff;
      slow_alpha_in = slow_alpha_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN:       gain_in       = csr_data;
            CSR_FAST_ALPHA: fast_alpha_in = csr_data;
            CSR_SLOW_ALPHA: slow_alpha_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ch_ff         <= 1'b0;
         slow_ff       <= 1'b0;
         bank_ff       <= 1'b0;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         gain_ff       <= GAIN_RESET;
         fast_alpha_ff <= FAST_ALPHA_RESET;
         slow_alpha_ff <= SLOW_ALPHA_RESET;
         for (int c = 0; c < 2; c++) begin
            for (int s = 0; s < 2; s++) begin
               for (int b = 0; b < 2; b++) begin
                  env_ff[c][s][b] <= '0;
               end
            end
         end
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         slow_ff       <= slow_in;
         bank_ff       <= bank_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
         gain_ff       <= gain_in;
         fast_alpha_ff <= fast_alpha_in;
         slow_alpha_ff <= slow_alpha_in;
         env_ff        <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff      <= samp_in;
      gmag_ff      <= gmag_in;
      neg_ff       <= neg_in;
      m_ff         <= m_in;
      d_ff         <= d_in;
      up_ff        <= up_in;
      acc_ff       <= acc_in;
      fe_ff        <= fe_in;
      se_ff        <= se_in;
      res_ff       <= res_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;

`ifndef ASSERT_OFF
   a_div_busy_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> state_ff == ST_DIV)
      else $error("Divider is busy outside the divide state.");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("Result became valid without a finished pair.");

   a_held_change: assert property (@(posedge clock) disable iff (reset)
      (!$stable(held_ff) && !$past(reset)) |-> $past(div_sts.done || req_accept))
      else $error("Held factor changed without a divide result or a transfer.");
`endif

endmodule
`default_nettype wire
